[hdl/utf8d_pkg.sv]
`default_nettype none

package utf8d_pkg;

    // Code point limits and replacement value
    localparam logic [20:0] REPL_CP  = 21'h00FFFD;
    localparam logic [20:0] MAX_CP   = 21'h10FFFF;
    localparam logic [20:0] SURR_LO  = 21'h00D800;
    localparam logic [20:0] SURR_HI  = 21'h00DFFF;
    localparam logic [20:0] MIN_CP_2 = 21'h000080;
    localparam logic [20:0] MIN_CP_3 = 21'h000800;
    localparam logic [20:0] MIN_CP_4 = 21'h010000;

    // Lead byte ranges
    localparam logic [7:0] LEAD2_LO = 8'hC2;
    localparam logic [7:0] LEAD2_HI = 8'hDF;
    localparam logic [7:0] LEAD3_LO = 8'hE0;
    localparam logic [7:0] LEAD3_HI = 8'hEF;
    localparam logic [7:0] LEAD4_LO = 8'hF0;
    localparam logic [7:0] LEAD4_HI = 8'hF4;
    localparam logic [1:0] CONT_TAG = 2'b10;

    // Four bytes, index 0 is the oldest
    typedef logic [3:0][7:0] t_win;

    typedef struct packed {
        logic [20:0] code_point;
        logic        replaced;
        logic        run_last;
        logic        text_done;
    } t_result;

    // Decode of the window that starts at one byte position
    typedef struct packed {
        logic [2:0]  len;
        logic        incomplete;
        logic        valid;
        logic [20:0] cp;
    } t_pos;

    // Everything one byte produces: results and the next held state
    typedef struct packed {
        t_result [3:0]   res;
        logic [2:0]      res_cnt;
        logic [2:0][7:0] held;
        logic [1:0]      held_cnt;
        logic [2:0]      seq_len;
    } t_dec;

    // Sequence length announced by a lead byte, zero for a bad lead
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        begin
            len = 3'd0;
            if (b[7] == 1'b0) begin
                len = 3'd1;
            end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
                len = 3'd2;
            end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
                len = 3'd3;
            end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
                len = 3'd4;
            end
            return len;
        end
    endfunction

    // Check and assemble one sequence of the given length
    function automatic t_pos decode_pos(input logic [2:0] len, input t_win w,
                                        input logic [2:0] avail);
        t_pos        p;
        logic        ok;
        logic [20:0] cp;
        begin
            p.len        = len;
            p.incomplete = (len != 3'd0) && (avail < len);
            ok           = (len != 3'd0) && (avail >= len);
            cp           = '0;
            unique case (len)
                3'd1: begin
                    cp = {14'd0, w[0][6:0]};
                end
                3'd2: begin
                    cp = {10'd0, w[0][4:0], w[1][5:0]};
                    ok = ok && (w[1][7:6] == CONT_TAG) && (cp >= MIN_CP_2);
                end
                3'd3: begin
                    cp = {5'd0, w[0][3:0], w[1][5:0], w[2][5:0]};
                    ok = ok && (w[1][7:6] == CONT_TAG) && (w[2][7:6] == CONT_TAG)
                            && (cp >= MIN_CP_3);
                end
                3'd4: begin
                    cp = {w[0][2:0], w[1][5:0], w[2][5:0], w[3][5:0]};
                    ok = ok && (w[1][7:6] == CONT_TAG) && (w[2][7:6] == CONT_TAG)
                            && (w[3][7:6] == CONT_TAG) && (cp >= MIN_CP_4);
                end
                default: begin
                    cp = '0;
                end
            endcase
            ok      = ok && (cp <= MAX_CP) && !((cp >= SURR_LO) && (cp <= SURR_HI));
            p.valid = ok;
            p.cp    = cp;
            return p;
        end
    endfunction

endpackage

`default_nettype wire

[hdl/utf8d_window_decode.sv]
`default_nettype none

module utf8d_window_decode (
    input  wire logic [2:0][7:0] i_held,
    input  wire logic [1:0]      i_held_cnt,
    input  wire logic [2:0]      i_seq_len,
    input  wire logic [7:0]      i_data_byte,
    input  wire logic            i_text_end,
    output utf8d_pkg::t_dec      o_dec
);

    utf8d_pkg::t_win win;
    utf8d_pkg::t_win sh  [4];
    utf8d_pkg::t_pos pos [4];
    logic [2:0]      n;

    // Build the window: held bytes then the new byte, and its shifted views
    always_comb begin
        n   = {1'b0, i_held_cnt} + 3'd1;
        win = '0;
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < {1'b0, i_held_cnt}) begin
                win[i] = (i < 3) ? i_held[2'(i)] : 8'd0;
            end else if (3'(i) == {1'b0, i_held_cnt}) begin
                win[i] = i_data_byte;
            end
        end
        for (int p = 0; p < 4; p++) begin
            sh[p] = win >> (8 * p);
        end
    end

    // Decode every start position in parallel
    always_comb begin
        for (int p = 0; p < 4; p++) begin
            if (p == 0 && i_held_cnt != 2'd0) begin
                pos[p] = utf8d_pkg::decode_pos(i_seq_len, sh[p], n);
            end else begin
                pos[p] = utf8d_pkg::decode_pos(utf8d_pkg::lead_len(win[p]), sh[p],
                                               3'(n - 3'(p)));
            end
        end
    end

    // Walk the window: emit results, advance by a sequence or by one byte
    always_comb begin
        logic [2:0] s;
        logic       go;
        logic [1:0] sel;
        s     = 3'd0;
        go    = 1'b1;
        o_dec = '0;
        for (int j = 0; j < 4; j++) begin
            sel = s[1:0];
            if (go && (s < n)) begin
                if (pos[sel].incomplete && !i_text_end) begin
                    go = 1'b0;
                end else begin
                    o_dec.res[j].code_point = pos[sel].valid ? pos[sel].cp
                                                             : utf8d_pkg::REPL_CP;
                    o_dec.res[j].replaced   = !pos[sel].valid;
                    s             = s + (pos[sel].valid ? pos[sel].len : 3'd1);
                    o_dec.res_cnt = 3'(j + 1);
                end
            end else begin
                go = 1'b0;
            end
        end

        // Flag the last result of this byte
        if (o_dec.res_cnt != 3'd0) begin
            o_dec.res[2'(o_dec.res_cnt - 3'd1)].run_last  = 1'b1;
            o_dec.res[2'(o_dec.res_cnt - 3'd1)].text_done = i_text_end;
        end

        // Keep the unfinished tail, drop everything at the end of the text
        sel       = s[1:0];
        o_dec.held = sh[sel][2:0];
        if (i_text_end) begin
            o_dec.held_cnt = 2'd0;
        end else begin
            o_dec.held_cnt = 2'(n - s);
        end
        o_dec.seq_len = (o_dec.held_cnt != 2'd0) ? pos[sel].len : 3'd0;
    end

endmodule

`default_nettype wire

[hdl/utf8_stream_decoder_top.sv]
`default_nettype none
// Path: an accepted byte is held in the input register, then decoded into the result
// buffer. Throughput: one byte per cycle while each byte yields at most one result and
// the output is not stalled; a byte that yields more results (up to four) stalls the
// input as the result buffer drains one beat per cycle, unless stalled, through the output port.
// Reset: synchronous, active low; clears held byte count, pending input and results.

module utf8_stream_decoder_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_text_end,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [20:0]      o_code_point,
    output logic             o_replaced,
    output logic             o_run_last,
    output logic             o_text_done
);

    // Input register
    logic r_iv, n_iv;
    logic [7:0] r_ibyte;
    logic       r_iend;

    // Decoder state
    logic [2:0][7:0] r_held;
    logic [1:0]      r_held_cnt, n_held_cnt;
    logic [2:0]      r_seq_len, n_seq_len;

    // Result buffer
    utf8d_pkg::t_result [3:0] r_res;
    logic [2:0]               r_cnt, n_cnt;
    logic [1:0]               r_rd, n_rd;

    utf8d_pkg::t_dec dec;
    logic            out_take;
    logic            consume;
    logic            in_take;

    utf8d_window_decode u_decode (
        .i_held      (r_held),
        .i_held_cnt  (r_held_cnt),
        .i_seq_len   (r_seq_len),
        .i_data_byte (r_ibyte),
        .i_text_end  (r_iend),
        .o_dec       (dec)
    );

    // Handshake: decode the held byte once the buffer is empty or on its last beat
    assign out_take = o_valid && !i_stall;
    assign consume  = r_iv && ((r_cnt == 3'd0) || ((r_cnt == 3'd1) && out_take));
    assign o_stall  = r_iv && !consume;
    assign in_take  = i_valid && !o_stall;

    // Next-state logic
    always_comb begin
        n_iv       = r_iv;
        n_held_cnt = r_held_cnt;
        n_seq_len  = r_seq_len;
        n_cnt      = r_cnt;
        n_rd       = r_rd;
        if (out_take) begin
            n_cnt = r_cnt - 3'd1;
            n_rd  = r_rd + 2'd1;
        end
        if (consume) begin
            n_iv       = 1'b0;
            n_held_cnt = dec.held_cnt;
            n_seq_len  = dec.seq_len;
            n_cnt      = dec.res_cnt;
            n_rd       = 2'd0;
        end
        if (in_take) begin
            n_iv = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv       <= 1'b0;
            r_held_cnt <= 2'd0;
            r_seq_len  <= 3'd0;
            r_cnt      <= 3'd0;
            r_rd       <= 2'd0;
        end else begin
            r_iv       <= n_iv;
            r_held_cnt <= n_held_cnt;
            r_seq_len  <= n_seq_len;
            r_cnt      <= n_cnt;
            r_rd       <= n_rd;
        end
    end

    // Payload registers: capture input beat, held bytes and results
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_ibyte <= i_data_byte;
            r_iend  <= i_text_end;
        end
        if (consume) begin
            r_held <= dec.held;
            r_res  <= dec.res;
        end
    end

    // Present the current result beat
    assign o_valid      = (r_cnt != 3'd0);
    assign o_code_point = r_res[r_rd].code_point;
    assign o_replaced   = r_res[r_rd].replaced;
    assign o_run_last   = r_res[r_rd].run_last;
    assign o_text_done  = r_res[r_rd].text_done;

endmodule

`default_nettype wire

[test/tb.sv]
`default_nettype none

module tb;

    localparam int IDLE_LIMIT   = 1000;
    localparam int HOLD_CYCLES  = 150;
    localparam int RANDOM_BYTES = 300;
    localparam int DRAIN_CYCLES = 20;

    // Shapes of one random character in a generated text
    typedef enum int {
        CH_GOOD,
        CH_NOISE,
        CH_CUT,
        CH_OVERLONG,
        CH_SURROGATE,
        CH_TOO_BIG,
        CH_BAD_CONT
    } t_char_kind;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_text_end;
    logic        o_valid;
    logic        i_stall;
    logic [20:0] o_code_point;
    logic        o_replaced;
    logic        o_run_last;
    logic        o_text_done;

    // Decoder state as predicted from the accepted bytes
    logic [7:0]          held_q [3];
    int                  held_n;
    utf8d_pkg::t_result  pending_chars [$];
    utf8d_pkg::t_result  want;

    // Bytes of the text about to be sent
    logic [7:0]  text_buf [$];

    int          err_count;
    int          bytes_sent;
    int          chars_seen;
    int          repl_seen;
    int          random_bytes;
    int          idle_cycles;
    int          hold_left;
    bit          quiet;
    bit          hold_req;

    utf8_stream_decoder_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_byte  (i_data_byte),
        .i_text_end   (i_text_end),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_code_point (o_code_point),
        .o_replaced   (o_replaced),
        .o_run_last   (o_run_last),
        .o_text_done  (o_text_done)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Sequence length opened by a lead byte, zero when it cannot lead
    function automatic int char_len(input logic [7:0] b);
        if (!b[7]) return 1;
        if (b >= utf8d_pkg::LEAD2_LO && b <= utf8d_pkg::LEAD2_HI) return 2;
        if (b >= utf8d_pkg::LEAD3_LO && b <= utf8d_pkg::LEAD3_HI) return 3;
        if (b >= utf8d_pkg::LEAD4_LO && b <= utf8d_pkg::LEAD4_HI) return 4;
        return 0;
    endfunction

    // Decode the held bytes plus one new byte, queue the code points it yields
    function automatic void decode_byte(input logic [7:0] b, input logic last);
        logic [7:0]          win [4];
        utf8d_pkg::t_result  res [$];
        utf8d_pkg::t_result  one;
        int                  n;
        int                  start;
        int                  len;
        int                  k;
        logic                ok;
        logic [20:0]         cp;
        logic [20:0]         floor_cp;
        logic [7:0]          c;
        n     = held_n;
        start = 0;
        for (k = 0; k < n; k++) win[k] = held_q[k];
        win[n] = b;
        n++;
        while (start < n && res.size() < 4) begin
            len = char_len(win[start]);
            // wait for the rest of the window unless the text ends here
            if (len != 0 && n - start < len && !last) break;
            ok       = (len != 0) && (n - start >= len);
            cp       = '0;
            floor_cp = '0;
            if (ok) begin
                unique case (len)
                    1: cp = {14'd0, win[start][6:0]};
                    2: begin
                        cp       = {16'd0, win[start][4:0]};
                        floor_cp = utf8d_pkg::MIN_CP_2;
                    end
                    3: begin
                        cp       = {17'd0, win[start][3:0]};
                        floor_cp = utf8d_pkg::MIN_CP_3;
                    end
                    default: begin
                        cp       = {18'd0, win[start][2:0]};
                        floor_cp = utf8d_pkg::MIN_CP_4;
                    end
                endcase
                for (k = 1; k < len; k++) begin
                    c = win[start + k];
                    if (c[7:6] != utf8d_pkg::CONT_TAG) ok = 1'b0;
                    cp = {cp[14:0], c[5:0]};
                end
                ok = ok && cp >= floor_cp && cp <= utf8d_pkg::MAX_CP &&
                     !(cp >= utf8d_pkg::SURR_LO && cp <= utf8d_pkg::SURR_HI);
            end
            one.code_point = ok ? cp : utf8d_pkg::REPL_CP;
            one.replaced   = !ok;
            one.run_last   = 1'b0;
            one.text_done  = 1'b0;
            res.insert(res.size(), one);
            // drop only the lead of a bad window, rescan the rest
            start += ok ? len : 1;
        end
        held_n = last ? 0 : n - start;
        for (k = 0; k < held_n; k++) held_q[k] = win[start + k];
        if (res.size() > 0) begin
            res[res.size() - 1].run_last  = 1'b1;
            res[res.size() - 1].text_done = last;
        end
        for (k = 0; k < res.size(); k++) pending_chars.insert(pending_chars.size(), res[k]);
    endfunction

    // Offer one byte, hold it until accepted, then predict its results
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!quiet && $urandom_range(99) < 6) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_text_end  <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        decode_byte(b, last);
        bytes_sent++;
    endtask

    // Send the whole text buffer, flagging its final byte if asked
    task automatic send_buffer(input logic end_flag);
        int k;
        for (k = 0; k < text_buf.size(); k++) begin
            send_byte(text_buf[k], end_flag && k == text_buf.size() - 1);
        end
        text_buf.delete();
    endtask

    // Append one random character, mostly well formed, sometimes broken
    function automatic void add_char();
        t_char_kind  kind;
        int          nb;
        int          k;
        logic [20:0] cp;
        logic [7:0]  enc [4];
        logic [7:0]  junk;
        kind = ($urandom_range(99) < 85) ? CH_GOOD : t_char_kind'($urandom_range(1, 6));
        nb   = int'($urandom_range(1, 4));
        unique case (nb)
            1: cp = 21'($urandom_range(0, 'h7F));
            2: cp = 21'($urandom_range('h80, 'h7FF));
            3: begin
                cp = 21'($urandom_range('h800, 'hFFFF));
                if (cp >= utf8d_pkg::SURR_LO && cp <= utf8d_pkg::SURR_HI) begin
                    cp = cp - 21'h800;
                end
            end
            default: cp = 21'($urandom_range('h10000, 'h10FFFF));
        endcase
        unique case (kind)
            CH_NOISE: begin
                text_buf.insert(text_buf.size(), 8'($urandom_range(255)));
                return;
            end
            CH_OVERLONG: begin
                nb = int'($urandom_range(2, 4));
                cp = 21'($urandom_range(0, nb == 2 ? 'h7F : (nb == 3 ? 'h7FF : 'hFFFF)));
            end
            CH_SURROGATE: begin
                nb = 3;
                cp = 21'($urandom_range(utf8d_pkg::SURR_LO, utf8d_pkg::SURR_HI));
            end
            CH_TOO_BIG: begin
                nb = 4;
                cp = 21'($urandom_range('h110000, 'h1FFFFF));
            end
            default: ;
        endcase
        unique case (nb)
            1: enc[0] = {1'b0, cp[6:0]};
            2: begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {utf8d_pkg::CONT_TAG, cp[5:0]};
            end
            3: begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {utf8d_pkg::CONT_TAG, cp[11:6]};
                enc[2] = {utf8d_pkg::CONT_TAG, cp[5:0]};
            end
            default: begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {utf8d_pkg::CONT_TAG, cp[17:12]};
                enc[2] = {utf8d_pkg::CONT_TAG, cp[11:6]};
                enc[3] = {utf8d_pkg::CONT_TAG, cp[5:0]};
            end
        endcase
        if (kind == CH_CUT && nb > 1) nb--;
        if (kind == CH_BAD_CONT && nb > 1) begin
            junk = 8'($urandom_range(255));
            if (junk[7:6] == utf8d_pkg::CONT_TAG) junk[6] = 1'b1;
            enc[$urandom_range(1, nb - 1)] = junk;
        end
        for (k = 0; k < nb; k++) text_buf.insert(text_buf.size(), enc[k]);
    endfunction

    // Single bytes: ASCII extremes and bytes that can never lead
    task automatic test_single_bytes();
        text_buf = '{8'h00, 8'h7F, 8'h80, 8'hC1, 8'hF5, 8'hFF};
        send_buffer(1'b0);
    endtask

    // Shortest legal two-byte encoding and longest legal three- and four-byte encodings
    task automatic test_valid_forms();
        text_buf = '{8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_buffer(1'b1);
    endtask

    // Lead followed by a byte that is not a continuation
    task automatic test_non_continuation();
        text_buf = '{8'hC2, 8'h7F};
        send_buffer(1'b0);
    endtask

    // Overlong, surrogate and above-range windows, each one a replacement burst
    task automatic test_rejected_values();
        text_buf = '{8'hE0, 8'h80, 8'h80, 8'hED, 8'hA0, 8'h80,
                     8'hF4, 8'h90, 8'h80, 8'h80};
        send_buffer(1'b0);
    endtask

    // Text that ends in the middle of a sequence
    task automatic test_cut_short();
        text_buf = '{8'hF0, 8'h9F};
        send_buffer(1'b1);
    endtask

    // Hold the output off while bytes keep coming so the input backs up
    task automatic test_output_hold();
        int k;
        hold_req = 1'b1;
        for (k = 0; k < 30; k++) text_buf.insert(text_buf.size(), 8'($urandom_range(0, 'h7F)));
        text_buf.insert(text_buf.size(), 8'hF4);
        text_buf.insert(text_buf.size(), 8'h90);
        text_buf.insert(text_buf.size(), 8'h80);
        text_buf.insert(text_buf.size(), 8'h80);
        send_buffer(1'b1);
    endtask

    // Random texts, the first third with no idling on either side
    task automatic test_random_text();
        int nchars;
        quiet = 1'b1;
        while (random_bytes < RANDOM_BYTES) begin
            if (random_bytes >= RANDOM_BYTES / 3) quiet = 1'b0;
            nchars = $urandom_range(1, 12);
            repeat (nchars) add_char();
            random_bytes += text_buf.size();
            send_buffer($urandom_range(3) != 0);
        end
        quiet = 1'b0;
    endtask

    function automatic void check_field(input string name, input logic [20:0] want_v,
                                        input logic [20:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s expected %h got %h", $time, name, want_v, got_v);
            err_count++;
        end
    endfunction

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (quiet) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < 6);
        end
    end

    // Compare each accepted beat with the oldest predicted code point
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected result, code_point %h", $time, o_code_point);
                err_count++;
            end else begin
                want = pending_chars.pop_front();
                check_field("code_point", want.code_point, o_code_point);
                check_field("replaced", 21'(want.replaced), 21'(o_replaced));
                check_field("run_last", 21'(want.run_last), 21'(o_run_last));
                check_field("text_done", 21'(want.text_done), 21'(o_text_done));
                chars_seen++;
                if (want.replaced) repl_seen++;
            end
        end
    end

    // Watchdog: give up after too many cycles with no beat on either side
    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_data_byte  = '0;
        i_text_end   = 1'b0;
        i_stall      = 1'b0;
        quiet        = 1'b0;
        hold_req     = 1'b0;
        hold_left    = 0;
        held_n       = 0;
        err_count    = 0;
        bytes_sent   = 0;
        chars_seen   = 0;
        repl_seen    = 0;
        random_bytes = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_single_bytes();
        test_valid_forms();
        test_non_continuation();
        test_rejected_values();
        test_cut_short();
        test_output_hold();
        test_random_text();

        // Drain: wait for every predicted code point, then a few more cycles
        i_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Decoded %0d bytes into %0d code points, %0d of them replacements.",
                 bytes_sent, chars_seen, repl_seen);
        $display("Included bad leads, overlong, surrogate, out-of-range, truncated texts",
                 " and a long output hold-off.");
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
